FILE: src/mha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mha_pkg: shared types and constants
// Payload structs and the CORDIC arctangent table for the heading block.
// ----------------------------------------------------------------------------
package mha_pkg;

  localparam int unsigned TableFrac = 20;

  typedef struct packed {
    logic [7:0] x_high;
    logic [7:0] x_low;
    logic [7:0] z_high;
    logic [7:0] z_low;
    logic [7:0] y_high;
    logic [7:0] y_low;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic [8:0]         bearing_deg;
    logic [8:0]         roll_deg;
    logic [8:0]         pitch_deg;
  } out_beat_t;

  // atan(2^-i) in degrees with 20 fractional bits, rounded to nearest.
  function automatic logic [25:0] atan_tab(input logic [4:0] i);
    logic [25:0] v;
    case (i)
      5'd0:  v = 26'd47185920;
      5'd1:  v = 26'd27855475;
      5'd2:  v = 26'd14718068;
      5'd3:  v = 26'd7471121;
      5'd4:  v = 26'd3750058;
      5'd5:  v = 26'd1876857;
      5'd6:  v = 26'd938658;
      5'd7:  v = 26'd469357;
      5'd8:  v = 26'd234682;
      5'd9:  v = 26'd117342;
      5'd10: v = 26'd58671;
      5'd11: v = 26'd29335;
      5'd12: v = 26'd14668;
      5'd13: v = 26'd7334;
      5'd14: v = 26'd3667;
      5'd15: v = 26'd1833;
      5'd16: v = 26'd917;
      5'd17: v = 26'd458;
      5'd18: v = 26'd229;
      5'd19: v = 26'd115;
      5'd20: v = 26'd57;
      5'd21: v = 26'd29;
      5'd22: v = 26'd14;
      5'd23: v = 26'd7;
      5'd24: v = 26'd4;
      5'd25: v = 26'd2;
      5'd26: v = 26'd1;
      default: v = 26'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: src/mha_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels carrying the readout and the result beats.
// ----------------------------------------------------------------------------
interface mha_in_if;
  logic             valid;
  logic             ready;
  mha_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mha_out_if;
  logic              valid;
  logic              ready;
  mha_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/mha_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mha_cordic: pipelined vectoring CORDIC
// One atan2 per beat, one micro-rotation per register stage, whole degrees out.
// ----------------------------------------------------------------------------
module mha_cordic #(
  parameter int unsigned CordicStages  = 18,
  parameter int unsigned AngleFracBits = 10
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [16:0] num_i,
  input  wire logic signed [16:0] den_i,
  output logic [8:0]              deg_o
);

  localparam int unsigned VW = 17 + CordicStages + 2;
  localparam int unsigned ZW = AngleFracBits + 11;
  localparam int unsigned Sh = mha_pkg::TableFrac - AngleFracBits;
  localparam logic signed [ZW-1:0] HalfTurn = ZW'(180) <<< AngleFracBits;
  localparam logic signed [ZW-1:0] FullTurn = ZW'(360) <<< AngleFracBits;

  logic signed [VW-1:0] n_q [CordicStages+1];
  logic signed [VW-1:0] d_q [CordicStages+1];
  logic signed [ZW-1:0] z_q [CordicStages+1];
  logic                 zero_q [CordicStages+1];
  logic [8:0]           deg_q;

  function automatic logic signed [ZW-1:0] step_ang(input int unsigned i);
    logic [25:0] t;
    t = mha_pkg::atan_tab(5'(i));
    return ZW'((27'(t) + (27'd1 << (Sh - 1))) >> Sh);
  endfunction

  // Entry stage: half turn for a negative denominator, and the exact case
  // of a zero numerator, which skips the micro-rotations.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (num_i == '0);
      if (num_i == '0) begin
        n_q[0] <= '0;
        d_q[0] <= '0;
        z_q[0] <= (den_i < 0) ? HalfTurn : '0;
      end else if (den_i < 0) begin
        n_q[0] <= VW'(-num_i) <<< CordicStages;
        d_q[0] <= VW'(-den_i) <<< CordicStages;
        z_q[0] <= HalfTurn;
      end else begin
        n_q[0] <= VW'(num_i) <<< CordicStages;
        d_q[0] <= VW'(den_i) <<< CordicStages;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar g = 0; g < CordicStages; g++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[g+1] <= zero_q[g];
        if (zero_q[g]) begin
          n_q[g+1] <= n_q[g];
          d_q[g+1] <= d_q[g];
          z_q[g+1] <= z_q[g];
        end else if (n_q[g] > 0) begin
          d_q[g+1] <= d_q[g] + (n_q[g] >>> g);
          n_q[g+1] <= n_q[g] - (d_q[g] >>> g);
          z_q[g+1] <= z_q[g] + step_ang(g);
        end else begin
          d_q[g+1] <= d_q[g] - (n_q[g] >>> g);
          n_q[g+1] <= n_q[g] + (d_q[g] >>> g);
          z_q[g+1] <= z_q[g] - step_ang(g);
        end
      end
    end
  end

  logic signed [ZW-1:0] tot;
  always_comb begin
    tot = z_q[CordicStages];
    if (tot < 0) begin
      tot = tot + FullTurn;
    end else if (tot >= FullTurn) begin
      tot = tot - FullTurn;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      deg_q <= tot[AngleFracBits +: 9];
    end
  end

  assign deg_o = deg_q;

endmodule
`default_nettype wire

FILE: src/magnetometer_heading_angles.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// magnetometer_heading_angles
// Assembles X, Z, Y readings and computes bearing, roll and pitch in degrees.
// ----------------------------------------------------------------------------
//   Channel  Dir  Beat contents
//   in_if    in   six bytes: x_high, x_low, z_high, z_low, y_high, y_low
//   out_if   out  axis_x, axis_y, axis_z, bearing_deg, roll_deg, pitch_deg
//
// A readout beat is accepted every cycle while the pipeline can advance.
// The pipeline has one input register, one entry stage, one stage per
// micro-rotation and one wrap-and-truncate stage.
// The whole pipeline advances as one; when the output holds a beat that is
// not taken, every stage freezes, so nothing is lost or repeated.
// Reset clears only the valid bits; the data path carries no reset.
// ----------------------------------------------------------------------------
module magnetometer_heading_angles #(
  parameter int unsigned CORDIC_STAGES   = 18,
  parameter int unsigned ANGLE_FRAC_BITS = 10
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mha_in_if.sink    in_if,
  mha_out_if.source out_if
);

  // Depth: input register, CORDIC entry, rotations, wrap stage.
  localparam int unsigned Depth = CORDIC_STAGES + 3;

  logic             adv;
  logic [Depth-1:0] vld_q;
  logic signed [15:0] ax_q [Depth];
  logic signed [15:0] ay_q [Depth];
  logic signed [15:0] az_q [Depth];
  logic [8:0] bear, roll, pitch;

  // The pipeline moves when the last stage is empty or being taken.
  assign adv         = !vld_q[Depth-1] || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_if.valid};
    end
  end

  // The axis values ride along with the angle pipeline.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q[0] <= {in_if.data.x_high, in_if.data.x_low};
      ay_q[0] <= {in_if.data.y_high, in_if.data.y_low};
      az_q[0] <= {in_if.data.z_high, in_if.data.z_low};
      for (int k = 1; k < Depth; k++) begin
        ax_q[k] <= ax_q[k-1];
        ay_q[k] <= ay_q[k-1];
        az_q[k] <= az_q[k-1];
      end
    end
  end

  // Negation in 17 bits so that -(-32768) stays exact.
  logic signed [16:0] x17, y17, z17;
  assign x17 = 17'(ax_q[0]);
  assign y17 = 17'(ay_q[0]);
  assign z17 = 17'(az_q[0]);

  mha_cordic #(.CordicStages(CORDIC_STAGES), .AngleFracBits(ANGLE_FRAC_BITS))
    u_bear (.clk_i, .en_i(adv), .num_i(x17), .den_i(-y17), .deg_o(bear));
  mha_cordic #(.CordicStages(CORDIC_STAGES), .AngleFracBits(ANGLE_FRAC_BITS))
    u_roll (.clk_i, .en_i(adv), .num_i(x17), .den_i(-z17), .deg_o(roll));
  mha_cordic #(.CordicStages(CORDIC_STAGES), .AngleFracBits(ANGLE_FRAC_BITS))
    u_pitch (.clk_i, .en_i(adv), .num_i(y17), .den_i(-z17), .deg_o(pitch));

  assign out_if.valid            = vld_q[Depth-1];
  assign out_if.data.axis_x      = ax_q[Depth-1];
  assign out_if.data.axis_y      = ay_q[Depth-1];
  assign out_if.data.axis_z      = az_q[Depth-1];
  assign out_if.data.bearing_deg = bear;
  assign out_if.data.roll_deg    = roll;
  assign out_if.data.pitch_deg   = pitch;

endmodule
`default_nettype wire

FILE: src/mha_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mha_checker: port-level checks
// Watches the handshakes and result ranges of the heading block.
// ----------------------------------------------------------------------------
module mha_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic [8:0] bearing_i,
  input wire logic [8:0] roll_i,
  input wire logic [8:0] pitch_i
);

  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |-> !in_ready_i)
    else $error("input taken during stall");

  a_free_takes_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i) else $error("idle output but input held off");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (bearing_i < 9'd360 && roll_i < 9'd360 && pitch_i < 9'd360))
    else $error("angle out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(bearing_i)))
    else $error("stalled result changed");

endmodule

bind magnetometer_heading_angles mha_checker u_mha_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_i(in_if.ready),
  .out_valid_i(out_if.valid), .out_ready_i(out_if.ready),
  .bearing_i(out_if.data.bearing_deg), .roll_i(out_if.data.roll_deg),
  .pitch_i(out_if.data.pitch_deg)
);
`default_nettype wire
